// ----- hdl/fbpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg: shared definitions for the fixed block pool allocator
// Command and status codes, field widths and the block count reset value.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 2;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [STAT_W-1:0]  status_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam cmd_t CMD_ALLOC   = 2'd0;
    localparam cmd_t CMD_FREE    = 2'd1;
    localparam cmd_t CMD_REBUILD = 2'd2;

    localparam status_t STATUS_OK          = 2'd0;
    localparam status_t STATUS_EMPTY       = 2'd1;
    localparam status_t STATUS_DOUBLE_FREE = 2'd2;
    localparam status_t STATUS_RANGE       = 2'd3;

    localparam count_t BLOCK_COUNT_RESET = 9'd256;

endpackage

`default_nettype wire

// ----- hdl/fixed_block_pool_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: LIFO free-list allocator for equal-sized blocks
// Hands out and takes back block indexes from a singly linked free list
// stored as a next-link memory plus a head register.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Direction  Transfer when
//  --------  -----------------------------------  ---------  -------------------------
//  command   cmd_valid, cmd_stall, cmd,            in         cmd_valid && !cmd_stall
//            block_index
//  response  rsp_valid, rsp_stall, status,         out        rsp_valid && !rsp_stall
//            granted_block
//  config    cfg_we, cfg_wdata (block_count)       in         cfg_we
//
//  Allocate goes from transfer to a loaded response register by way of
//  acceptance, the registered read of the head's link and the reply; an
//  allocate on an empty list skips the read. Free walks the free list one
//  link per cycle through the single read port of the link memory; an index
//  out of range skips the walk. Rebuild sweeps the link memory one entry per
//  cycle through its single write port. After reset the same sweep runs, with
//  cmd_stall high, before the first command is taken. A stalled response holds
//  the block in its reply state; a new command is taken once the reply is
//  loaded into the response register.
//
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    // Configuration
    input  wire logic    cfg_we,
    input  wire count_t  cfg_wdata,
    // Command channel
    input  wire logic    cmd_valid,
    output logic         cmd_stall,
    input  wire cmd_t    cmd,
    input  wire index_t  block_index,
    // Response channel
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output status_t      status,
    output index_t       granted_block
);

    // Link width holds NUM_BLOCKS itself, which marks the end of the list.
    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    // Compare width covers both the links and the 9-bit block count.
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);
    localparam logic [LW-1:0] LAST_IDX  = LW'(NUM_BLOCKS - 1);
    localparam logic [CW-1:0] NUM_CW    = CW'(NUM_BLOCKS);

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_REPLY = 3'd4;

    logic [2:0]    state_reg, state_next;
    count_t        block_count_reg;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] sweep_idx_reg, sweep_idx_next;
    logic          sweep_reply_reg, sweep_reply_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic          walk_first_reg, walk_first_next;
    index_t        blk_reg, blk_next;
    status_t       res_status_reg, res_status_next;
    index_t        res_granted_reg, res_granted_next;
    logic          rsp_valid_reg, rsp_valid_next;
    status_t       rsp_status_reg, rsp_status_next;
    index_t        rsp_granted_reg, rsp_granted_next;

    // Link memory: one write port, one registered read port.
    logic [LW-1:0] link_mem [NUM_BLOCKS];
    logic [LW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;

    logic [CW-1:0] bc_ext;
    logic [CW-1:0] used_cw;
    logic [LW-1:0] cur;
    logic          cmd_xfer;
    logic          rsp_xfer;

    // The block count register is clamped to 1 .. NUM_BLOCKS wherever used.
    assign bc_ext  = CW'(block_count_reg);
    assign used_cw = (bc_ext == '0) ? CW'(1) : ((bc_ext > NUM_CW) ? NUM_CW : bc_ext);

    // During a walk the current node is the head on the first step and the
    // link just read on every later step.
    assign cur = walk_first_reg ? head_reg : rd_data_reg;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign rsp_xfer  = rsp_valid_reg && !rsp_stall;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        sweep_idx_next   = sweep_idx_reg;
        sweep_reply_next = sweep_reply_reg;
        steps_next       = steps_reg;
        walk_first_next  = walk_first_reg;
        blk_next         = blk_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        rsp_valid_next   = rsp_xfer ? 1'b0 : rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_granted_next = rsp_granted_reg;
        rd_addr          = cur[IW-1:0];
        mem_we           = 1'b0;
        mem_waddr        = sweep_idx_reg[IW-1:0];
        mem_wdata        = NULL_LINK;

        case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_idx_reg[IW-1:0];
                if ((CW'(sweep_idx_reg) + CW'(1)) < used_cw)
                begin
                    mem_wdata = sweep_idx_reg + LW'(1);
                end
                if (sweep_idx_reg == LAST_IDX)
                begin
                    head_next  = '0;
                    state_next = sweep_reply_reg ? ST_REPLY : ST_IDLE;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + LW'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    blk_next         = block_index;
                    res_status_next  = STATUS_OK;
                    res_granted_next = '0;
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            if (head_reg >= NULL_LINK)
                            begin
                                res_status_next = STATUS_EMPTY;
                                state_next      = ST_REPLY;
                            end
                            else
                            begin
                                rd_addr    = head_reg[IW-1:0];
                                state_next = ST_ALLOC;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (CW'(block_index) >= used_cw)
                            begin
                                res_status_next = STATUS_RANGE;
                                state_next      = ST_REPLY;
                            end
                            else
                            begin
                                steps_next      = '0;
                                walk_first_next = 1'b1;
                                state_next      = ST_WALK;
                            end
                        end
                        CMD_REBUILD:
                        begin
                            sweep_idx_next   = '0;
                            sweep_reply_next = 1'b1;
                            state_next       = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            ST_ALLOC:
            begin
                // The head's link arrived from the read issued at transfer.
                res_granted_next = INDEX_W'(head_reg);
                head_next        = rd_data_reg;
                state_next       = ST_REPLY;
            end

            ST_WALK:
            begin
                walk_first_next = 1'b0;
                if ((cur >= NULL_LINK) || (steps_reg == NULL_LINK))
                begin
                    // Not on the list: push it in front of the head.
                    mem_we     = 1'b1;
                    mem_waddr  = IW'(blk_reg);
                    mem_wdata  = head_reg;
                    head_next  = LW'(blk_reg);
                    state_next = ST_REPLY;
                end
                else if (CW'(cur) == CW'(blk_reg))
                begin
                    res_status_next = STATUS_DOUBLE_FREE;
                    state_next      = ST_REPLY;
                end
                else
                begin
                    rd_addr    = cur[IW-1:0];
                    steps_next = steps_reg + LW'(1);
                end
            end

            ST_REPLY:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = res_status_reg;
                    rsp_granted_next = res_granted_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            block_count_reg <= BLOCK_COUNT_RESET;
            head_reg        <= '0;
            sweep_idx_reg   <= '0;
            sweep_reply_reg <= 1'b0;
            steps_reg       <= '0;
            walk_first_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            sweep_idx_reg   <= sweep_idx_next;
            sweep_reply_reg <= sweep_reply_next;
            steps_reg       <= steps_next;
            walk_first_reg  <= walk_first_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg         <= blk_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_granted_reg <= rsp_granted_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[rd_addr];
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign granted_block = rsp_granted_reg;

    // The head is a block index or the end-of-list mark, never beyond.
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NULL_LINK)
        else $error("free list head beyond end-of-list mark");

    // The walk counter never passes the bound on link reads.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (steps_reg <= NULL_LINK))
        else $error("free list walk ran past its bound");

    // A push during a walk only writes a block that passed the range check.
    a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && mem_we) |-> (CW'(blk_reg) < used_cw))
        else $error("push of an out-of-range block");

    // An allocate on a non-empty list goes through the link read.
    a_alloc_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_xfer && cmd == CMD_ALLOC && head_reg != NULL_LINK) |=>
        (state_reg == ST_ALLOC))
        else $error("allocate skipped the head link read");

    // Leaving the reply state always loads the response register.
    a_reply_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPLY && state_next == ST_IDLE) |=> rsp_valid_reg)
        else $error("reply left without a response");

endmodule

`default_nettype wire

// ----- bench/fixed_block_pool_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test: self-checking bench for the block allocator
// Drives allocate, free, rebuild and unused commands under several block
// counts and idle patterns, mirrors the free list in a local model of the
// pool, and compares every response against the model's prediction.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int POOL_SIZE = 256;
    // The free list uses the pool size as its end marker.
    localparam logic [8:0] LINK_END = 9'd256;
    // The fourth command code has no function and must answer with OK.
    localparam cmd_t CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASES = 8;

    typedef struct packed {
        status_t code;
        index_t  block;
    } reply_t;

    // DUT inputs are given known values from time zero.
    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_we = 1'b0;
    count_t  cfg_wdata = '0;
    logic    cmd_valid = 1'b0;
    cmd_t    cmd = CMD_ALLOC;
    index_t  block_index = '0;
    logic    rsp_stall = 1'b0;
    logic    cmd_stall;
    logic    rsp_valid;
    status_t status;
    index_t  granted_block;

    // Local copy of the pool: head register, next-link table and block count.
    logic [8:0] pool_head;
    logic [8:0] pool_link [POOL_SIZE];
    count_t     pool_count;

    reply_t expected_replies[$];
    index_t held_blocks[$];
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     failures = 0;
    int     quiet_cycles = 0;

    fixed_block_pool_allocator #(
        .NUM_BLOCKS (POOL_SIZE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .block_index   (block_index),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .granted_block (granted_block)
    );

    always #2 clk = ~clk;

    // The receiver stalls at random; the percentage changes from phase to phase.
    always @(negedge clk)
    begin
        rsp_stall = ($urandom_range(0, 99) < stall_pct);
    end

    // A zero or oversized block count is clamped into 1 .. pool size.
    function automatic logic [8:0] active_count();
        if (pool_count == 0)
            return 9'd1;
        if (pool_count > POOL_SIZE)
            return 9'(POOL_SIZE);
        return pool_count;
    endfunction

    // Chain blocks 0 .. count-1 in ascending order; the rest of the table
    // points at the end marker.
    function automatic void rebuild_pool();
        logic [8:0] n;
        n = active_count();
        for (int i = 0; i < POOL_SIZE; i++)
            pool_link[i] = (i + 1 < n) ? 9'(i + 1) : LINK_END;
        pool_head = '0;
    endfunction

    // Apply one command to the local pool and return the reply it must give.
    function automatic reply_t pool_apply(cmd_t c, index_t b);
        reply_t     r;
        logic [8:0] cur;
        int         steps;
        bit         found;
        r.code = STATUS_OK;
        r.block = '0;
        case (c)
            CMD_ALLOC:
            begin
                if (pool_head >= LINK_END)
                    r.code = STATUS_EMPTY;
                else
                begin
                    r.block = pool_head[7:0];
                    pool_head = pool_link[pool_head];
                end
            end
            CMD_FREE:
            begin
                if ({1'b0, b} >= active_count())
                    r.code = STATUS_RANGE;
                else
                begin
                    // The walk gives up after one link per pool entry.
                    cur = pool_head;
                    steps = 0;
                    found = 1'b0;
                    while (cur < LINK_END && steps < POOL_SIZE && !found)
                    begin
                        if (cur == {1'b0, b})
                            found = 1'b1;
                        else
                        begin
                            cur = pool_link[cur];
                            steps++;
                        end
                    end
                    if (found)
                        r.code = STATUS_DOUBLE_FREE;
                    else
                    begin
                        pool_link[b] = pool_head;
                        pool_head = {1'b0, b};
                    end
                end
            end
            CMD_REBUILD:
                rebuild_pool();
            default:
                ;
        endcase
        return r;
    endfunction

    // Send one command transfer. The valid stays high after acceptance so that
    // a following call can go out back to back; release_command lowers it.
    task automatic send_command(input cmd_t c, input index_t b);
        reply_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        cmd_valid = 1'b1;
        cmd = c;
        block_index = b;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        r = pool_apply(c, b);
        expected_replies.push_back(r);
        // Keep track of blocks that are out of the pool so that random frees
        // can hand them back.
        if (c == CMD_ALLOC && r.code == STATUS_OK)
            held_blocks.push_back(r.block);
        else if (c == CMD_REBUILD)
            held_blocks.delete();
        else if (c == CMD_FREE && r.code == STATUS_OK)
        begin
            for (int i = held_blocks.size() - 1; i >= 0; i--)
                if (held_blocks[i] == b)
                    held_blocks.delete(i);
        end
    endtask

    task automatic release_command();
        @(negedge clk);
        cmd_valid = 1'b0;
    endtask

    // Stop sending and wait until every outstanding response has come back.
    task automatic wait_drained();
        release_command();
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // The block count is only written while the allocator is idle.
    task automatic write_block_count(input count_t value);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        pool_count = value;
    endtask

    // Every response transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected response, status %0d block %0d",
                         $time, status, granted_block);
                failures++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.code)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.code, status);
                    failures++;
                end
                if (granted_block !== want.block)
                begin
                    $display("%0t: granted_block expected %0d, got %0d",
                             $time, want.block, granted_block);
                    failures++;
                end
            end
        end
    end

    // Watchdog: the run is hung when no transfer happens on either channel for
    // far longer than the slowest free-list walk.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("fixed_block_pool_allocator: mismatch");
            $finish;
        end
    end

    // After reset the list runs 0 .. 255. Allocations come out in order, a free
    // of the last block finds it deep in the list, and the unused code is a
    // no-op.
    task automatic test_reset_list();
        send_command(CMD_ALLOC, 8'hFF);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_ALLOC, 8'hA5);
        send_command(CMD_FREE, 8'd255);
        send_command(CMD_FREE, 8'd0);
        send_command(CMD_FREE, 8'd0);
        send_command(CMD_UNUSED, 8'hFF);
        send_command(CMD_ALLOC, 8'h5A);
    endtask

    // A pool of one block: it can be taken once, then the pool is empty.
    task automatic test_single_block();
        write_block_count(9'd1);
        send_command(CMD_REBUILD, 8'h00);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_FREE, 8'd1);
        send_command(CMD_FREE, 8'd0);
        send_command(CMD_FREE, 8'd0);
        send_command(CMD_ALLOC, 8'h00);
    endtask

    // A count of zero behaves as one block and an oversized count as the full
    // pool. A count change alone leaves the list alone but moves the range check.
    task automatic test_count_limits();
        write_block_count(9'd0);
        send_command(CMD_FREE, 8'd1);
        send_command(CMD_REBUILD, 8'h00);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_ALLOC, 8'h00);
        write_block_count(9'd511);
        send_command(CMD_FREE, 8'd255);
        send_command(CMD_REBUILD, 8'h00);
        send_command(CMD_ALLOC, 8'h00);
        write_block_count(9'd4);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_FREE, 8'd4);
        send_command(CMD_FREE, 8'd3);
    endtask

    // Mostly well-formed traffic: allocations and frees of held blocks, with
    // double frees, out-of-range frees, rebuilds and unused codes mixed in.
    task automatic test_random_traffic(input int phase, input count_t count);
        int     pick;
        index_t b;
        send_idle_pct = (phase % 4 == 1) ? 50 : (phase % 4 == 3) ? 38 : 0;
        stall_pct = (phase % 4 == 2) ? 50 : (phase % 4 == 3) ? 38 : 0;
        write_block_count(count);
        if ($urandom_range(0, 1))
            send_command(CMD_REBUILD, index_t'($urandom_range(0, 255)));
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            pick = $urandom_range(0, 99);
            b = index_t'($urandom_range(0, 255));
            if (pick < 35)
                send_command(CMD_ALLOC, b);
            else if (pick < 72 && held_blocks.size() != 0)
                send_command(CMD_FREE,
                             held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
            else if (pick < 82)
                send_command(CMD_FREE,
                             index_t'($urandom_range(0, active_count() - 1)));
            else if (pick < 88)
                send_command(CMD_FREE, b);
            else if (pick < 91)
                send_command(CMD_UNUSED, b);
            else if (pick < 94)
                send_command(CMD_REBUILD, b);
            else
                send_command(CMD_ALLOC, b);
            // Halfway through, hold off until the allocator has answered all.
            if (n == ITEMS_PER_PHASE / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        count_t phase_counts [PHASES];
        pool_count = BLOCK_COUNT_RESET;
        rebuild_pool();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_reset_list();
        test_single_block();
        test_count_limits();

        phase_counts[0] = 9'd256;
        phase_counts[1] = 9'd2;
        phase_counts[2] = 9'd0;
        phase_counts[3] = 9'd511;
        phase_counts[4] = count_t'($urandom_range(3, 64));
        phase_counts[5] = 9'd257;
        phase_counts[6] = 9'd1;
        phase_counts[7] = count_t'($urandom_range(0, 511));
        for (int p = 0; p < PHASES; p++)
            test_random_traffic(p, phase_counts[p]);

        // Drain, then leave room for a stray response after the last one.
        wait_drained();
        repeat (POOL_SIZE + 16) @(posedge clk);
        if (failures == 0)
            $display("fixed_block_pool_allocator: match");
        else
            $display("fixed_block_pool_allocator: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fbpa_pkg.sv
hdl/fixed_block_pool_allocator.sv
bench/fixed_block_pool_allocator_test.sv
